>>> rtl/bfra_pkg.sv
// Package for the best-fit range allocator: field widths, transfer payload types,
// status codes and the control and flag structs shared by the core and its scan unit.
// No dependencies.
package bfra_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int PAGE_W  = 20;
    localparam int COUNT_W = 21;
    localparam int STAMP_W = 32;

    localparam logic [COUNT_W-1:0] PAGE_SPACE = 21'h10_0000;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam int REG_FIRST_PAGE = 0;
    localparam int REG_PAGES      = 1;

    typedef struct packed {
        logic               mode;
        logic [COUNT_W-1:0] page_count;
        logic [PAGE_W-1:0]  page_number;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] first_page;
    } rsp_t;

    // One free table entry as it is stored in memory.
    typedef struct packed {
        logic [PAGE_W-1:0]  start;
        logic [COUNT_W-1:0] size;
        logic [STAMP_W-1:0] stamp;
    } free_ent_t;

    // One used table entry as it is stored in memory.
    typedef struct packed {
        logic [PAGE_W-1:0]  start;
        logic [COUNT_W-1:0] size;
    } used_ent_t;

    typedef struct packed {
        logic clear;
        logic eval;
    } scan_ctrl_t;

    typedef struct packed {
        logic best_found;
        logic hit_found;
        logic used_slot_found;
        logic free_slot_found;
    } scan_flags_t;

endpackage

>>> rtl/bfra_ram.sv
// Simple dual-port synchronous memory with one write port and one registered read port.
// Used for both allocator tables. No dependencies.
module bfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/bfra_scan.sv
// Scan unit of the allocator: looks at one entry of each table per cycle and keeps the
// best fitting free range, the matching used range and the first empty slot of each table.
// Depends on bfra_pkg.
module bfra_scan #(
    parameter int AW = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfra_pkg::scan_ctrl_t          ctrl,
    input  logic [AW-1:0]                 idx,
    input  logic [bfra_pkg::COUNT_W-1:0]  pages,
    input  logic [bfra_pkg::PAGE_W-1:0]   page,
    input  bfra_pkg::free_ent_t           free_ent,
    input  logic                          free_vld,
    input  bfra_pkg::used_ent_t           used_ent,
    input  logic                          used_vld,
    output bfra_pkg::scan_flags_t         flags,
    output logic [AW-1:0]                 best_idx,
    output bfra_pkg::free_ent_t           best_ent,
    output logic [AW-1:0]                 hit_idx,
    output bfra_pkg::used_ent_t           hit_ent,
    output logic [AW-1:0]                 used_slot,
    output logic [AW-1:0]                 free_slot
);

    bfra_pkg::scan_flags_t flags_reg, flags_next;
    logic [AW-1:0]         best_idx_reg, hit_idx_reg, used_slot_reg, free_slot_reg;
    bfra_pkg::free_ent_t   best_ent_reg;
    bfra_pkg::used_ent_t   hit_ent_reg;
    logic                  fit, better, hit, take_used, take_free;

    always_comb
    begin
        fit    = free_vld && (free_ent.size >= pages);
        // Smaller size wins; on equal size the later stamp wins.
        better = fit && (!flags_reg.best_found || (free_ent.size < best_ent_reg.size) ||
                 ((free_ent.size == best_ent_reg.size) &&
                  (free_ent.stamp > best_ent_reg.stamp)));
        hit       = !flags_reg.hit_found && used_vld && (used_ent.start == page);
        take_used = !flags_reg.used_slot_found && !used_vld;
        take_free = !flags_reg.free_slot_found && !free_vld;

        flags_next = flags_reg;
        if (ctrl.clear)
        begin
            flags_next = '0;
        end
        else if (ctrl.eval)
        begin
            flags_next.best_found      = flags_reg.best_found || better;
            flags_next.hit_found       = flags_reg.hit_found || hit;
            flags_next.used_slot_found = flags_reg.used_slot_found || take_used;
            flags_next.free_slot_found = flags_reg.free_slot_found || take_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.eval && !ctrl.clear)
        begin
            if (better)
            begin
                best_idx_reg <= idx;
                best_ent_reg <= free_ent;
            end
            if (hit)
            begin
                hit_idx_reg <= idx;
                hit_ent_reg <= used_ent;
            end
            if (take_used)
            begin
                used_slot_reg <= idx;
            end
            if (take_free)
            begin
                free_slot_reg <= idx;
            end
        end
    end

    assign flags     = flags_reg;
    assign best_idx  = best_idx_reg;
    assign best_ent  = best_ent_reg;
    assign hit_idx   = hit_idx_reg;
    assign hit_ent   = hit_ent_reg;
    assign used_slot = used_slot_reg;
    assign free_slot = free_slot_reg;

endmodule

>>> rtl/best_fit_range_allocator_core.sv
// Top level of the best-fit page range allocator: configuration port, control sequencer,
// the free and used table memories and the scan unit.
// Depends on bfra_pkg, bfra_ram and bfra_scan.
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  -------------------------------------
//  req       in         req_valid / req_stall  bfra_pkg::req_t (mode, count, page)
//  rsp       out        rsp_valid / rsp_stall  bfra_pkg::rsp_t (status, first_page)
//  cfg       in         APB psel / penable     region_first_page, region_pages
//
// A result follows its request transfer through the sequencer states: in S_SCAN both
// memories are read in step, one table entry at a time; S_LAST covers the read latency of
// the last entry, and S_DONE writes back both tables and the result. The request port
// opens again in the cycle after the write-back, so a new request is not taken before
// the last one has been written back.
// After reset, and after every register write, the state S_INIT writes the region into free
// entry 0; no request is taken during that state.
// A result waits in the output register while rsp_stall is high; the next request is
// taken meanwhile and its scan runs, and only its write-back waits for the register.
module best_fit_range_allocator_core #(
    parameter int TABLE_ENTRIES = bfra_pkg::TABLE_ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bfra_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bfra_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
    localparam int FREE_W = $bits(bfra_pkg::free_ent_t);
    localparam int USED_W = $bits(bfra_pkg::used_ent_t);

    // Sequencer states.
    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [AW-1:0]                  scan_idx_reg, scan_idx_next;
    logic [AW-1:0]                  rd_idx_reg;
    logic                           rd_pend_reg;
    bfra_pkg::req_t                 req_reg;
    logic [bfra_pkg::PAGE_W-1:0]    first_reg;
    logic [bfra_pkg::COUNT_W-1:0]   pages_reg;
    logic [TABLE_ENTRIES-1:0]       free_valid_reg, free_valid_next;
    logic [TABLE_ENTRIES-1:0]       used_valid_reg, used_valid_next;
    logic [bfra_pkg::STAMP_W-1:0]   counter_reg, counter_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    bfra_pkg::rsp_t                 rsp_reg, rsp_next;

    logic                           req_xfer, cfg_wr, commit;
    logic [bfra_pkg::COUNT_W-1:0]   room, clip_pages;

    logic                           free_we, used_we;
    logic [AW-1:0]                  free_waddr, used_waddr;
    bfra_pkg::free_ent_t            free_wdata, free_rdata;
    bfra_pkg::used_ent_t            used_wdata, used_rdata;

    bfra_pkg::scan_ctrl_t           scan_ctrl;
    bfra_pkg::scan_flags_t          flags;
    logic [AW-1:0]                  best_idx, hit_idx, used_slot, free_slot;
    bfra_pkg::free_ent_t            best_ent;
    bfra_pkg::used_ent_t            hit_ent;

    // Configuration port. Register writes are taken in the access phase; either one
    // starts the table initialization over.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == 1'(bfra_pkg::REG_PAGES))
        begin
            prdata = 32'(pages_reg);
        end
        else
        begin
            prdata = 32'(first_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            pages_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == 1'(bfra_pkg::REG_PAGES))
            begin
                pages_reg <= pwdata[bfra_pkg::COUNT_W-1:0];
            end
            else
            begin
                first_reg <= pwdata[bfra_pkg::PAGE_W-1:0];
            end
        end
    end

    // The region is clipped so that it never runs past the end of the page space.
    assign room       = bfra_pkg::PAGE_SPACE - bfra_pkg::COUNT_W'(first_reg);
    assign clip_pages = (pages_reg > room) ? room : pages_reg;

    assign req_xfer  = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign commit    = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    assign scan_ctrl.clear = req_xfer;
    assign scan_ctrl.eval  = rd_pend_reg;

    // Sequencer, valid bits, stamp counter and the result register.
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        free_valid_next = free_valid_reg;
        used_valid_next = used_valid_reg;
        counter_next    = counter_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;

        free_we    = 1'b0;
        free_waddr = '0;
        free_wdata = '0;
        used_we    = 1'b0;
        used_waddr = '0;
        used_wdata = '0;

        case (state_reg)
            S_INIT:
            begin
                free_we          = 1'b1;
                free_wdata.start = first_reg;
                free_wdata.size  = clip_pages;
                state_next       = S_IDLE;
            end
            S_IDLE:
            begin
                scan_idx_next = '0;
                if (req_xfer)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (commit)
                begin
                    state_next          = S_IDLE;
                    rsp_valid_next      = 1'b1;
                    rsp_next.first_page = '0;
                    if (req_reg.mode == bfra_pkg::MODE_ALLOC)
                    begin
                        if ((req_reg.page_count == '0) || !flags.best_found)
                        begin
                            rsp_next.status = bfra_pkg::ST_NOSPACE;
                        end
                        else if (!flags.used_slot_found)
                        begin
                            rsp_next.status = bfra_pkg::ST_FULL;
                        end
                        else
                        begin
                            rsp_next.status     = bfra_pkg::ST_OK;
                            rsp_next.first_page = best_ent.start;
                            used_we             = 1'b1;
                            used_waddr          = used_slot;
                            used_wdata.start    = best_ent.start;
                            used_wdata.size     = req_reg.page_count;
                            used_valid_next[used_slot] = 1'b1;
                            if (best_ent.size == req_reg.page_count)
                            begin
                                free_valid_next[best_idx] = 1'b0;
                            end
                            else
                            begin
                                // Split: the remainder keeps its slot and its stamp.
                                free_we          = 1'b1;
                                free_waddr       = best_idx;
                                free_wdata.start = best_ent.start +
                                                   req_reg.page_count[bfra_pkg::PAGE_W-1:0];
                                free_wdata.size  = best_ent.size - req_reg.page_count;
                                free_wdata.stamp = best_ent.stamp;
                            end
                        end
                    end
                    else
                    begin
                        if (!flags.hit_found)
                        begin
                            rsp_next.status = bfra_pkg::ST_UNKNOWN;
                        end
                        else if (!flags.free_slot_found)
                        begin
                            rsp_next.status = bfra_pkg::ST_FULL;
                        end
                        else
                        begin
                            rsp_next.status  = bfra_pkg::ST_OK;
                            free_we          = 1'b1;
                            free_waddr       = free_slot;
                            free_wdata.start = hit_ent.start;
                            free_wdata.size  = hit_ent.size;
                            free_wdata.stamp = counter_reg;
                            counter_next     = counter_reg + 1'b1;
                            free_valid_next[free_slot] = 1'b1;
                            used_valid_next[hit_idx]   = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // A register write resets both tables; the region lands in free entry 0 during
        // the following initialization cycle.
        if (cfg_wr)
        begin
            state_next      = S_INIT;
            free_valid_next = TABLE_ENTRIES'(1);
            used_valid_next = '0;
            counter_next    = 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            scan_idx_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            free_valid_reg <= TABLE_ENTRIES'(1);
            used_valid_reg <= '0;
            counter_reg    <= 32'd1;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            rd_pend_reg    <= (state_reg == S_SCAN);
            free_valid_reg <= free_valid_next;
            used_valid_reg <= used_valid_next;
            counter_reg    <= counter_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_idx_reg;
        rsp_reg    <= rsp_next;
        if (req_xfer)
        begin
            req_reg <= req;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Both tables are read at the scan index every cycle; the write port is used only
    // during initialization and write-back, when no scan is running.
    bfra_ram #(
        .WIDTH (FREE_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (scan_idx_reg),
        .rdata (free_rdata)
    );

    bfra_ram #(
        .WIDTH (USED_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .waddr (used_waddr),
        .wdata (used_wdata),
        .raddr (scan_idx_reg),
        .rdata (used_rdata)
    );

    bfra_scan #(
        .AW (AW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .idx       (rd_idx_reg),
        .pages     (req_reg.page_count),
        .page      (req_reg.page_number),
        .free_ent  (free_rdata),
        .free_vld  (free_valid_reg[rd_idx_reg]),
        .used_ent  (used_rdata),
        .used_vld  (used_valid_reg[rd_idx_reg]),
        .flags     (flags),
        .best_idx  (best_idx),
        .best_ent  (best_ent),
        .hit_idx   (hit_idx),
        .hit_ent   (hit_ent),
        .used_slot (used_slot),
        .free_slot (free_slot)
    );

endmodule

>>> rtl/bfra_checker.sv
// Port-level checker for the allocator core, attached by the bind statement at the end.
// Depends on bfra_pkg and best_fit_range_allocator_core.
module bfra_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input bfra_pkg::rsp_t rsp,
    input logic           psel,
    input logic           penable,
    input logic           pwrite,
    input logic           pready
);

    // A result that is held back stays in place until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("held result changed");

    // Only a successful allocation reports a first page.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != bfra_pkg::ST_OK) |-> rsp.first_page == '0)
        else $error("first page set on a failed request");

    // A request keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while a scan was starting");

    // A register write is followed by the initialization cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=> req_stall)
        else $error("request port open during table initialization");

endmodule

bind best_fit_range_allocator_core bfra_checker u_bfra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready)
);
